### rtl/pnbcd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pnbcd_pkg
// shared widths, character codes and nibble decode for the party number
// bcd decoder and its port checker
// ----------------------------------------------------------------------------
package pnbcd_pkg;

  localparam int PNBCD_MAX_DIGITS_DEF = 32;

  localparam int S_TDATA_W = 8;
  localparam int M_TDATA_W = 24;

  // ascii codes on the 7-bit character field
  localparam logic [6:0] CH_ZERO  = 7'h30;
  localparam logic [6:0] CH_NINE  = 7'h39;
  localparam logic [6:0] CH_STAR  = 7'h2A;
  localparam logic [6:0] CH_HASH  = 7'h23;
  localparam logic [6:0] CH_PLUS  = 7'h2B;
  localparam logic [6:0] CH_NONE  = 7'h00;

  localparam logic [3:0] NIB_STAR   = 4'd10;
  localparam logic [3:0] NIB_HASH   = 4'd11;
  localparam logic [3:0] NIB_FILLER = 4'hF;

  localparam logic [2:0] TYPE_INTL = 3'd1;

  // bcd nibble to ascii, spare codes read as zero
  function automatic logic [6:0] nibble_char(input logic [3:0] d);
    logic [6:0] c;
    c = CH_ZERO;
    case (d) inside
      [4'd0:4'd9]: c = CH_ZERO + {3'b000, d};
      NIB_STAR:    c = CH_STAR;
      NIB_HASH:    c = CH_HASH;
      default:     c = CH_ZERO;
    endcase
    return c;
  endfunction

endpackage

### rtl/party_number_bcd_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// party_number_bcd_decoder
// decodes called / calling party bcd number octets into ascii characters
// ----------------------------------------------------------------------------
// path: an accepted word is held in the input register, then decoded into the
//   result register pair, whose slot 0 shows its first result on the master side
// throughput: one word per cycle while m_axis_tready is high; a digit word giving
//   two characters holds the result register pair until its second one leaves
// reset: rst is synchronous, active high; clears the input and result
//   registers, returns to the header phase and zeroes the kept header fields
module party_number_bcd_decoder #(
  parameter int MAX_DIGITS = pnbcd_pkg::PNBCD_MAX_DIGITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // [7:0] value_byte
  input  logic [pnbcd_pkg::S_TDATA_W-1:0]  s_axis_tdata,
  // [0] calling_form
  input  logic [0:0]                       s_axis_tuser,
  input  logic                             s_axis_tlast,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // [6:0] digit_char, [9:7] number_type, [13:10] numbering_plan,
  // [14] octet3a_present, [16:15] presentation, [18:17] screening, [23:19] zero
  output logic [pnbcd_pkg::M_TDATA_W-1:0]  m_axis_tdata,
  // [0] char_valid
  output logic [0:0]                       m_axis_tuser,
  output logic                             m_axis_tlast
);
  import pnbcd_pkg::*;

  // counter holds 0..MAX_DIGITS
  localparam int CNT_W = $clog2(MAX_DIGITS + 1);
  localparam logic [CNT_W:0] MAX_EXT = (CNT_W + 1)'(MAX_DIGITS);

  // element phase
  localparam logic [1:0] PH_HEADER = 2'd0;
  localparam logic [1:0] PH_OCT3A  = 2'd1;
  localparam logic [1:0] PH_DIGITS = 2'd2;

  // ---------------- input register ----------------
  logic       in_valid;
  logic [7:0] in_byte;
  logic       in_form;
  logic       in_last;

  // ---------------- element state ----------------
  logic [1:0]       phase;
  logic [2:0]       kept_type;
  logic [3:0]       kept_plan;
  logic             kept_octet3a;
  logic [1:0]       kept_presentation;
  logic [1:0]       kept_screening;
  logic [CNT_W-1:0] chars_emitted;

  // ---------------- result register pair ----------------
  // slot 0 is on the bus; slot 1 holds the second character of a digit word
  logic [1:0] pair_cnt;
  logic [6:0] ch0;
  logic       v0;
  logic       last0;
  logic [6:0] ch1;
  logic       last1;

  // ---------------- decode ----------------
  logic             pair_free;
  logic             take;
  logic [CNT_W-1:0] cnt_base;
  logic [CNT_W:0]   cnt_plus1;
  logic             room0;
  logic             room1;
  logic [3:0]       lo_nib;
  logic [3:0]       hi_nib;
  logic [1:0]       n_chars;
  logic [1:0]       n_out;
  logic [6:0]       c0_next;
  logic [6:0]       c1_next;
  logic             v0_next;
  logic [1:0]       phase_next;

  // the slot pair can take a new word when empty or when its last result leaves now
  assign pair_free = (pair_cnt == 2'd0) || (m_axis_tready && pair_cnt == 2'd1);
  assign take      = in_valid && pair_free;
  assign s_axis_tready = !in_valid || take;

  assign lo_nib    = in_byte[3:0];
  assign hi_nib    = in_byte[7:4];
  // header restarts the count for this element
  assign cnt_base  = (phase == PH_HEADER) ? '0 : chars_emitted;
  assign cnt_plus1 = {1'b0, cnt_base} + (CNT_W + 1)'(1);
  assign room0     = {1'b0, cnt_base} < MAX_EXT;
  assign room1     = cnt_plus1 < MAX_EXT;

  always_comb begin
    n_chars    = 2'd0;
    c0_next    = CH_NONE;
    c1_next    = CH_NONE;
    phase_next = PH_DIGITS;
    case (phase)
      PH_HEADER: begin
        // '+' for international numbers, always within the limit
        if (in_byte[6:4] == TYPE_INTL) begin
          n_chars = 2'd1;
          c0_next = CH_PLUS;
        end
        phase_next = (in_form && !in_byte[7]) ? PH_OCT3A : PH_DIGITS;
      end
      PH_OCT3A: begin
        phase_next = PH_DIGITS;
      end
      default: begin
        // past the limit the word is dropped and an ending word reads as empty
        if (room0) begin
          c0_next = nibble_char(lo_nib);
          c1_next = nibble_char(hi_nib);
          n_chars = (hi_nib != NIB_FILLER && room1) ? 2'd2 : 2'd1;
        end
        phase_next = PH_DIGITS;
      end
    endcase
    if (in_last) begin
      phase_next = PH_HEADER;
    end
  end

  // an ending word with no character still yields one empty result
  assign v0_next = (n_chars != 2'd0);
  assign n_out   = (in_last && n_chars == 2'd0) ? 2'd1 : n_chars;

  // state update, once per decoded word
  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= PH_HEADER;
      kept_type         <= '0;
      kept_plan         <= '0;
      kept_octet3a      <= 1'b0;
      kept_presentation <= '0;
      kept_screening    <= '0;
      chars_emitted     <= '0;
    end else if (take) begin
      phase         <= phase_next;
      chars_emitted <= cnt_base + CNT_W'(n_chars);
      case (phase)
        PH_HEADER: begin
          kept_type         <= in_byte[6:4];
          kept_plan         <= in_byte[3:0];
          kept_octet3a      <= 1'b0;
          kept_presentation <= '0;
          kept_screening    <= '0;
        end
        PH_OCT3A: begin
          kept_octet3a      <= 1'b1;
          kept_presentation <= in_byte[6:5];
          kept_screening    <= in_byte[1:0];
        end
        default: begin
          kept_octet3a <= kept_octet3a;
        end
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte <= s_axis_tdata[7:0];
      in_form <= s_axis_tuser[0];
      in_last <= s_axis_tlast;
    end
  end

  // result slot count
  always_ff @(posedge clk) begin
    if (rst) begin
      pair_cnt <= 2'd0;
    end else if (take) begin
      pair_cnt <= n_out;
    end else if (m_axis_tvalid && m_axis_tready) begin
      pair_cnt <= pair_cnt - 2'd1;
    end
  end

  // result slot payload
  always_ff @(posedge clk) begin
    if (take) begin
      ch0   <= c0_next;
      v0    <= v0_next;
      last0 <= in_last && (n_out == 2'd1);
      ch1   <= c1_next;
      last1 <= in_last;
    end else if (m_axis_tvalid && m_axis_tready && pair_cnt == 2'd2) begin
      // second character moves up
      ch0   <= ch1;
      v0    <= 1'b1;
      last0 <= last1;
    end
  end

  // kept fields already reflect the word whose results are on the bus
  assign m_axis_tvalid = (pair_cnt != 2'd0);
  assign m_axis_tdata  = {5'b00000, kept_screening, kept_presentation, kept_octet3a,
                          kept_plan, kept_type, ch0};
  assign m_axis_tuser  = v0;
  assign m_axis_tlast  = last0;

endmodule

### rtl/pnbcd_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pnbcd_checker
// port level checks for the party number bcd decoder
// ----------------------------------------------------------------------------
module pnbcd_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             s_axis_tvalid,
  input logic                             s_axis_tready,
  input logic [pnbcd_pkg::S_TDATA_W-1:0]  s_axis_tdata,
  input logic [0:0]                       s_axis_tuser,
  input logic                             s_axis_tlast,
  input logic                             m_axis_tvalid,
  input logic                             m_axis_tready,
  input logic [pnbcd_pkg::M_TDATA_W-1:0]  m_axis_tdata,
  input logic [0:0]                       m_axis_tuser,
  input logic                             m_axis_tlast
);
  import pnbcd_pkg::*;

  logic [6:0] ch;
  assign ch = m_axis_tdata[6:0];

  // stalled word holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser) && $stable(m_axis_tlast))
    else $error("output word changed while stalled");

  // nothing comes out right after reset
  a_reset: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("output valid after reset");

  // an empty result closes the element and carries no character
  a_empty: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tlast && ch == CH_NONE)
    else $error("empty result malformed");

  // characters are digits, star, hash or plus
  a_char: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser[0] |->
      (ch >= CH_ZERO && ch <= CH_NINE) || ch == CH_STAR || ch == CH_HASH
      || ch == CH_PLUS)
    else $error("bad character");

  // indicators are zero without octet 3a
  a_ind: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tdata[14] |-> m_axis_tdata[18:15] == 4'd0)
    else $error("indicators set without octet 3a");

endmodule

bind party_number_bcd_decoder pnbcd_checker u_pnbcd_checker (.*);
